### hdl/voxel_face_quad_emitter_assert.svh
// assertion macros for the checker file
`ifndef VOXEL_FACE_QUAD_EMITTER_ASSERT_SVH
`define VOXEL_FACE_QUAD_EMITTER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define VFQE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define VFQE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vfqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vfqe_pkg;

  localparam int unsigned ATLAS_TILES_PER_ROW_DEF = 64;

  localparam int unsigned TILE_W     = 12;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_CHUNK_X = 1'b0;
  localparam logic REG_CHUNK_Z = 1'b1;

  // sides; codes at or above the count are invalid
  localparam logic [2:0] SIDE_POS_X = 3'd0;
  localparam logic [2:0] SIDE_NEG_X = 3'd1;
  localparam logic [2:0] SIDE_POS_Y = 3'd2;
  localparam logic [2:0] SIDE_NEG_Y = 3'd3;
  localparam logic [2:0] SIDE_POS_Z = 3'd4;
  localparam logic [2:0] SIDE_NEG_Z = 3'd5;
  localparam logic [2:0] SIDE_COUNT = 3'd6;

  localparam logic [6:0] TEX_MAX = 7'd127;

  typedef struct packed {
    logic dx;
    logic dy;
    logic dz;
    logic du;
    logic dv;
  } corner_t;

  // per side, per corner offsets
  function automatic corner_t corner_f(input logic [2:0] side, input logic [1:0] corner);
    corner_t c;
    c = '0;
    case (side)
      SIDE_POS_X: begin
        case (corner)
          2'd0:    c = 5'b00001;
          2'd1:    c = 5'b00111;
          2'd2:    c = 5'b01110;
          default: c = 5'b01000;
        endcase
      end
      SIDE_NEG_X: begin
        case (corner)
          2'd0:    c = 5'b10011;
          2'd1:    c = 5'b11010;
          2'd2:    c = 5'b11100;
          default: c = 5'b10101;
        endcase
      end
      SIDE_POS_Y: begin
        case (corner)
          2'd0:    c = 5'b00000;
          2'd1:    c = 5'b10001;
          2'd2:    c = 5'b10111;
          default: c = 5'b00110;
        endcase
      end
      SIDE_NEG_Y: begin
        case (corner)
          2'd0:    c = 5'b01000;
          2'd1:    c = 5'b01101;
          2'd2:    c = 5'b11111;
          default: c = 5'b11010;
        endcase
      end
      SIDE_POS_Z: begin
        case (corner)
          2'd0:    c = 5'b00011;
          2'd1:    c = 5'b01010;
          2'd2:    c = 5'b11000;
          default: c = 5'b10001;
        endcase
      end
      SIDE_NEG_Z: begin
        case (corner)
          2'd0:    c = 5'b00101;
          2'd1:    c = 5'b10111;
          2'd2:    c = 5'b11110;
          default: c = 5'b01100;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // corner used by each of the six index words
  function automatic logic [1:0] quad_order_f(input logic [2:0] k);
    logic [1:0] q;
    case (k)
      3'd0:    q = 2'd0;
      3'd1:    q = 2'd1;
      3'd2:    q = 2'd2;
      3'd3:    q = 2'd2;
      3'd4:    q = 2'd3;
      default: q = 2'd0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

### hdl/voxel_face_quad_emitter.sv
// voxel face quad emitter: one cube face in, four vertex words then six index words out
// a taken face sets item_valid_q, then its first word is loaded into the output register
// throughput: one word per cycle while out_stall_i is low, set by the single output
//   register; an invalid side gives only the six index words, and a clear emits nothing
// reset: rst_ni clears the vertex counter, the chunk offsets and all valid flags
`timescale 1ns / 1ps
`default_nettype none

module voxel_face_quad_emitter #(
  parameter int unsigned ATLAS_TILES_PER_ROW = vfqe_pkg::ATLAS_TILES_PER_ROW_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,

  // apb configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [vfqe_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [vfqe_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [vfqe_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready,

  // face input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 operation_i,
  input  wire logic signed [15:0]                   block_x_i,
  input  wire logic signed [15:0]                   block_y_i,
  input  wire logic signed [15:0]                   block_z_i,
  input  wire logic        [2:0]                    face_side_i,
  input  wire logic        [11:0]                   tile_index_i,

  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      result_kind_o,
  output logic signed [17:0]                        pos_x_o,
  output logic signed [16:0]                        pos_y_o,
  output logic signed [17:0]                        pos_z_o,
  output logic        [6:0]                         tex_u_o,
  output logic        [6:0]                         tex_v_o,
  output logic signed [16:0]                        origin_x_o,
  output logic signed [15:0]                        origin_y_o,
  output logic signed [16:0]                        origin_z_o,
  output logic        [31:0]                        index_value_o,
  output logic                                      last_of_run_o
);

  localparam int unsigned TILE_W = vfqe_pkg::TILE_W;
  localparam int unsigned CFG_W  = vfqe_pkg::CFG_W;

  // tile div by a constant: multiply by a rounded-up reciprocal, exact for 12-bit tiles
  localparam int unsigned     DIV_SHIFT = TILE_W + $clog2(ATLAS_TILES_PER_ROW);
  localparam longint unsigned DIV_MULT  =
    ((64'd1 << DIV_SHIFT) + ATLAS_TILES_PER_ROW - 1) / ATLAS_TILES_PER_ROW;
  localparam int unsigned     MULT_W    = $clog2(DIV_MULT + 1);
  localparam int unsigned     PROD_W    = TILE_W + MULT_W;
  // remainder width: holds ATLAS_TILES_PER_ROW - 1
  localparam int unsigned     TU_W      = $clog2(ATLAS_TILES_PER_ROW);
  // atlas sum width before saturation
  localparam int unsigned     TEX_SUM_W = TILE_W + 1;

  // word slots within one face: four vertex words then six index words
  localparam logic [3:0] FIRST_INDEX_SLOT = 4'd4;
  localparam logic [3:0] LAST_SLOT        = 4'd9;
  localparam logic [3:0] FIRST_SLOT       = 4'd0;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] chunk_x_q, chunk_x_d;
  logic [CFG_W-1:0] chunk_z_q, chunk_z_d;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // word aligned: the low address bits are not decoded
  always_comb begin
    chunk_x_d = chunk_x_q;
    chunk_z_d = chunk_z_q;
    if (cfg_write) begin
      unique case (paddr[2])
        vfqe_pkg::REG_CHUNK_X: chunk_x_d = pwdata[CFG_W-1:0];
        vfqe_pkg::REG_CHUNK_Z: chunk_z_d = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      vfqe_pkg::REG_CHUNK_X: prdata = {{(vfqe_pkg::APB_DATA_W-CFG_W){1'b0}}, chunk_x_q};
      vfqe_pkg::REG_CHUNK_Z: prdata = {{(vfqe_pkg::APB_DATA_W-CFG_W){1'b0}}, chunk_z_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input stage: one face held while its words are emitted
  // ---------------------------------------------------------------------------
  logic        in_fire;
  logic        out_adv;
  logic        emit;
  logic        slot_last;
  logic        side_ok;

  logic        item_valid_q, item_valid_d;
  logic [3:0]  slot_q, slot_d;
  logic [31:0] vertex_count_q, vertex_count_d;

  // face payload, captured on acceptance
  logic [16:0]       ox_q, ox_d;
  logic [15:0]       by_q;
  logic [16:0]       oz_q, oz_d;
  logic [2:0]        side_q;
  logic [TILE_W-1:0] tile_q;
  logic [TILE_W-1:0] tv_q, tv_d;
  logic [31:0]       base_q;
  logic [PROD_W-1:0] div_prod;

  // output register frees up when empty or when its word is taken
  assign out_adv    = !out_valid_o || !out_stall_i;
  assign emit       = item_valid_q && out_adv;
  assign slot_last  = (slot_q == LAST_SLOT);
  // a new face may come in the cycle the last word of the previous one is loaded
  assign in_stall_o = item_valid_q && !(out_adv && slot_last);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign side_ok    = (face_side_i < vfqe_pkg::SIDE_COUNT);

  assign ox_d     = {chunk_x_q[CFG_W-1], chunk_x_q} + {block_x_i[15], block_x_i};
  assign oz_d     = {chunk_z_q[CFG_W-1], chunk_z_q} + {block_z_i[15], block_z_i};
  assign div_prod = PROD_W'(tile_index_i) * PROD_W'(DIV_MULT);
  assign tv_d     = TILE_W'(div_prod >> DIV_SHIFT);

  // the counter moves at acceptance, so each face snapshots its own base
  always_comb begin
    vertex_count_d = vertex_count_q;
    item_valid_d   = item_valid_q;
    slot_d         = slot_q;
    if (emit) begin
      slot_d = slot_q + 4'd1;
      if (slot_last) begin
        item_valid_d = 1'b0;
      end
    end
    if (in_fire) begin
      if (operation_i == vfqe_pkg::OP_CLEAR) begin
        vertex_count_d = '0;
        item_valid_d   = 1'b0;
      end else begin
        item_valid_d = 1'b1;
        slot_d       = side_ok ? FIRST_SLOT : FIRST_INDEX_SLOT;
        if (side_ok) begin
          vertex_count_d = vertex_count_q + 32'd4;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_x_q      <= '0;
      chunk_z_q      <= '0;
      vertex_count_q <= '0;
      item_valid_q   <= 1'b0;
      slot_q         <= FIRST_SLOT;
    end else begin
      chunk_x_q      <= chunk_x_d;
      chunk_z_q      <= chunk_z_d;
      vertex_count_q <= vertex_count_d;
      item_valid_q   <= item_valid_d;
      slot_q         <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ox_q   <= ox_d;
      by_q   <= block_y_i;
      oz_q   <= oz_d;
      side_q <= face_side_i;
      tile_q <= tile_index_i;
      tv_q   <= tv_d;
      base_q <= vertex_count_q;
    end
  end

  // ---------------------------------------------------------------------------
  // word build for the current slot
  // ---------------------------------------------------------------------------
  logic                 is_vertex;
  vfqe_pkg::corner_t    corner;
  logic [2:0]           index_k;
  logic [1:0]           quad;
  logic [TILE_W-1:0]    tu_full;
  logic [TU_W-1:0]      tu;
  logic [TEX_SUM_W-1:0] tu_sum;
  logic [TEX_SUM_W-1:0] tv_sum;

  logic        kind_d;
  logic [17:0] pos_x_d;
  logic [16:0] pos_y_d;
  logic [17:0] pos_z_d;
  logic [6:0]  tex_u_d;
  logic [6:0]  tex_v_d;
  logic [16:0] origin_x_d;
  logic [15:0] origin_y_d;
  logic [16:0] origin_z_d;
  logic [31:0] index_d;
  logic        last_d;

  assign is_vertex = (slot_q < FIRST_INDEX_SLOT);
  assign corner    = vfqe_pkg::corner_f(side_q, slot_q[1:0]);
  assign index_k   = 3'(slot_q - FIRST_INDEX_SLOT);
  assign quad      = vfqe_pkg::quad_order_f(index_k);

  // remainder from the registered quotient, a constant multiply
  assign tu_full = tile_q - TILE_W'(tv_q * TILE_W'(ATLAS_TILES_PER_ROW));
  assign tu      = TU_W'(tu_full);
  assign tu_sum  = TEX_SUM_W'(tu) + TEX_SUM_W'(corner.du);
  assign tv_sum  = TEX_SUM_W'(tv_q) + TEX_SUM_W'(corner.dv);

  always_comb begin
    kind_d     = vfqe_pkg::KIND_INDEX;
    pos_x_d    = '0;
    pos_y_d    = '0;
    pos_z_d    = '0;
    tex_u_d    = '0;
    tex_v_d    = '0;
    origin_x_d = '0;
    origin_y_d = '0;
    origin_z_d = '0;
    index_d    = '0;
    last_d     = 1'b0;
    if (is_vertex) begin
      kind_d     = vfqe_pkg::KIND_VERTEX;
      pos_x_d    = {ox_q[16], ox_q} + {17'd0, corner.dx};
      pos_y_d    = {by_q[15], by_q} + {16'd0, corner.dy};
      pos_z_d    = {oz_q[16], oz_q} + {17'd0, corner.dz};
      // saturation matters for u with wide atlas rows and for v with narrow ones
      tex_u_d    = (tu_sum > TEX_SUM_W'(vfqe_pkg::TEX_MAX)) ? vfqe_pkg::TEX_MAX : tu_sum[6:0];
      tex_v_d    = (tv_sum > TEX_SUM_W'(vfqe_pkg::TEX_MAX)) ? vfqe_pkg::TEX_MAX : tv_sum[6:0];
      origin_x_d = ox_q;
      origin_y_d = by_q;
      origin_z_d = oz_q;
    end else begin
      index_d = base_q + {30'd0, quad};
      last_d  = slot_last;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_valid_d;

  assign out_valid_d = out_adv ? item_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_kind_o <= kind_d;
      pos_x_o       <= pos_x_d;
      pos_y_o       <= pos_y_d;
      pos_z_o       <= pos_z_d;
      tex_u_o       <= tex_u_d;
      tex_v_o       <= tex_v_d;
      origin_x_o    <= origin_x_d;
      origin_y_o    <= origin_y_d;
      origin_z_o    <= origin_z_d;
      index_value_o <= index_d;
      last_of_run_o <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hdl/vfqe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "voxel_face_quad_emitter_assert.svh"

module vfqe_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               result_kind_o,
  input wire logic signed [16:0] origin_x_o,
  input wire logic signed [15:0] origin_y_o,
  input wire logic signed [16:0] origin_z_o,
  input wire logic        [31:0] index_value_o,
  input wire logic               last_of_run_o
);

  logic out_take;
  logic vertex_word;

  assign out_take    = out_valid_o && !out_stall_i;
  assign vertex_word = out_valid_o && (result_kind_o == vfqe_pkg::KIND_VERTEX);

  // a stalled word holds
  `VFQE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_kind_o) && $stable(index_value_o) && $stable(last_of_run_o) && $stable(origin_x_o), "stalled result word changed")

  // words of one face come without gaps
  `VFQE_ASSERT_NXT(a_run_no_gap, out_take && !last_of_run_o, out_valid_o, "gap inside a face run")

  // a face always ends on an index word
  `VFQE_ASSERT_IMP(a_vertex_not_last, vertex_word, !last_of_run_o, "vertex word marked last")

  // consecutive vertex words belong to one face
  `VFQE_ASSERT_NXT(a_origin_steady, out_take && vertex_word, !vertex_word || ($stable(origin_x_o) && $stable(origin_y_o) && $stable(origin_z_o)), "origin changed within a face")

endmodule

bind voxel_face_quad_emitter vfqe_checker u_vfqe_checker (.*);

`default_nettype wire
